[hw/rtl/tcce_pkg.sv]
package tcce_pkg;

   // field widths
   localparam int CELL_W  = 8;
   localparam int COUNT_W = 9;
   localparam int GLYPH_W = 7;
   localparam int CMD_W   = 3;
   localparam int CHAR_W  = 8;
   localparam int CSR_W   = 2;

   // screen geometry limits
   localparam int TAB_STOP           = 8;
   localparam int MAX_CELLS_PER_AXIS = 256;
   localparam int CMP_W              = 13;

   // runs waiting between front and back end
   localparam int QUEUE_DEPTH = 4;

   typedef logic [CMD_W-1:0] command_type;

   // drawing commands
   localparam command_type CMD_ERASE_CURSOR = 3'd0;
   localparam command_type CMD_DRAW_GLYPH   = 3'd1;
   localparam command_type CMD_CLEAR_CELL   = 3'd2;
   localparam command_type CMD_SCROLL       = 3'd3;
   localparam command_type CMD_DRAW_CURSOR  = 3'd4;

   // character codes
   localparam logic [CHAR_W-1:0] CHAR_BS       = 8'd8;
   localparam logic [CHAR_W-1:0] CHAR_TAB      = 8'd9;
   localparam logic [CHAR_W-1:0] CHAR_LF       = 8'd10;
   localparam logic [CHAR_W-1:0] CHAR_CR       = 8'd13;
   localparam logic [CHAR_W-1:0] CHAR_PRINT_LO = 8'd32;
   localparam logic [CHAR_W-1:0] CHAR_PRINT_HI = 8'd126;

   // register indexes
   localparam logic [CSR_W-1:0] CSR_COLUMN_COUNT = 2'd0;
   localparam logic [CSR_W-1:0] CSR_ROW_COUNT    = 2'd1;
   localparam logic [CSR_W-1:0] CSR_SHOW_CURSOR  = 2'd2;

   // register reset values
   localparam logic [COUNT_W-1:0] COLUMN_COUNT_RESET = 9'd80;
   localparam logic [COUNT_W-1:0] ROW_COUNT_RESET    = 9'd25;
   localparam logic               SHOW_CURSOR_RESET  = 1'b1;

   typedef struct packed {
      logic [COUNT_W-1:0] column_count;
      logic [COUNT_W-1:0] row_count;
      logic               show_cursor;
   } cfg_type;

   // everything the back end needs to play out one character's commands
   typedef struct packed {
      logic               show;
      logic               act_valid;
      logic               act_clear;
      logic [CELL_W-1:0]  act_column;
      logic [GLYPH_W-1:0] glyph;
      logic               scroll;
      logic [CELL_W-1:0]  old_column;
      logic [CELL_W-1:0]  old_row;
      logic [CELL_W-1:0]  new_column;
      logic [CELL_W-1:0]  new_row;
   } run_type;

   // zero acts as one, oversize clamps to the axis limit
   function automatic logic [COUNT_W-1:0] effective_count(input logic [COUNT_W-1:0] value);
      logic [CMP_W-1:0] wide;
      wide = CMP_W'(value);
      if (value == '0) begin
         return COUNT_W'(1);
      end else if (wide > CMP_W'(MAX_CELLS_PER_AXIS)) begin
         return COUNT_W'(MAX_CELLS_PER_AXIS);
      end else begin
         return value;
      end
   endfunction

endpackage

[hw/rtl/tcce_front.sv]
module tcce_front (
   input  logic                              clock,
   input  logic                              reset,
   input  tcce_pkg::cfg_type                 cfg,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [tcce_pkg::CHAR_W-1:0]       req_char_byte,
   output logic                              push,
   output tcce_pkg::run_type                 push_run,
   input  logic                              queue_full
);

   localparam int CellW      = tcce_pkg::CELL_W;
   localparam int CountW     = tcce_pkg::COUNT_W;
   localparam int GlyphW     = tcce_pkg::GLYPH_W;
   localparam int TableDepth = 2 ** CellW;

   logic [CellW-1:0]  cursor_column_ff;
   logic [CellW-1:0]  cursor_column_in;
   logic [CellW-1:0]  cursor_row_ff;
   logic [CellW-1:0]  cursor_row_in;

   logic [CountW-1:0] tab_next [TableDepth];
   logic [CountW-1:0] cols;
   logic [CountW-1:0] rows;
   logic [CountW-1:0] col_a;
   logic [CountW-1:0] row_a;
   logic [CountW-1:0] col_b;
   logic [CountW-1:0] row_b;
   logic [CountW-1:0] row_c;
   logic              act_valid;
   logic              act_clear;
   logic [CellW-1:0]  act_column;
   logic [GlyphW-1:0] glyph;
   logic              scroll;
   logic              accept;

   // next tab stop for every column
   genvar g;
   generate
      for (g = 0; g < TableDepth; g++) begin : g_tab
         assign tab_next[g] = CountW'((g / tcce_pkg::TAB_STOP + 1) * tcce_pkg::TAB_STOP);
      end
   endgenerate

   // classify the character and work out the new cursor
   always_comb begin
      cols       = tcce_pkg::effective_count(cfg.column_count);
      rows       = tcce_pkg::effective_count(cfg.row_count);
      col_a      = {1'b0, cursor_column_ff};
      row_a      = {1'b0, cursor_row_ff};
      act_valid  = 1'b0;
      act_clear  = 1'b0;
      act_column = cursor_column_ff;
      glyph      = '0;
      unique case (req_char_byte) inside
         tcce_pkg::CHAR_LF: begin
            col_a = '0;
            row_a = row_a + CountW'(1);
         end
         tcce_pkg::CHAR_CR: begin
            col_a = '0;
         end
         tcce_pkg::CHAR_TAB: begin
            if (tab_next[cursor_column_ff] >= cols) begin
               col_a = '0;
               row_a = row_a + CountW'(1);
            end else begin
               col_a = tab_next[cursor_column_ff];
            end
         end
         tcce_pkg::CHAR_BS: begin
            if (cursor_column_ff != '0) begin
               col_a      = col_a - CountW'(1);
               act_valid  = 1'b1;
               act_clear  = 1'b1;
               act_column = cursor_column_ff - CellW'(1);
            end
         end
         [tcce_pkg::CHAR_PRINT_LO : tcce_pkg::CHAR_PRINT_HI]: begin
            act_valid = 1'b1;
            glyph     = req_char_byte[GlyphW-1:0];
            col_a     = col_a + CountW'(1);
         end
         default: begin
         end
      endcase

      // column wrap
      if (col_a >= cols) begin
         col_b = '0;
         row_b = row_a + CountW'(1);
      end else begin
         col_b = col_a;
         row_b = row_a;
      end

      // bottom of screen pins the row and scrolls
      scroll = (row_b >= rows);
      row_c  = scroll ? (rows - CountW'(1)) : row_b;
   end

   // handshake and run descriptor
   assign req_stall = queue_full;
   assign accept    = req_valid && !queue_full;
   assign push      = accept && (cfg.show_cursor || act_valid || scroll);

   assign push_run.show       = cfg.show_cursor;
   assign push_run.act_valid  = act_valid;
   assign push_run.act_clear  = act_clear;
   assign push_run.act_column = act_column;
   assign push_run.glyph      = glyph;
   assign push_run.scroll     = scroll;
   assign push_run.old_column = cursor_column_ff;
   assign push_run.old_row    = cursor_row_ff;
   assign push_run.new_column = cursor_column_in;
   assign push_run.new_row    = cursor_row_in;

   assign cursor_column_in = col_b[CellW-1:0];
   assign cursor_row_in    = row_c[CellW-1:0];

   // cursor position
   always_ff @(posedge clock) begin
      if (reset) begin
         cursor_column_ff <= '0;
         cursor_row_ff    <= '0;
      end else if (accept) begin
         cursor_column_ff <= cursor_column_in;
         cursor_row_ff    <= cursor_row_in;
      end
   end

endmodule

[hw/rtl/tcce_queue.sv]
module tcce_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  tcce_pkg::run_type push_run,
   output logic              full,
   input  logic              pop,
   output tcce_pkg::run_type pop_run,
   output logic              empty
);

   localparam int Depth = tcce_pkg::QUEUE_DEPTH;
   localparam int PtrW  = $clog2(Depth);

   tcce_pkg::run_type slots_ff [Depth];
   logic [PtrW-1:0]   wr_ptr_ff;
   logic [PtrW-1:0]   wr_ptr_in;
   logic [PtrW-1:0]   rd_ptr_ff;
   logic [PtrW-1:0]   rd_ptr_in;
   logic [PtrW:0]     count_ff;
   logic [PtrW:0]     count_in;

   assign full    = (count_ff == (PtrW+1)'(Depth));
   assign empty   = (count_ff == '0);
   assign pop_run = slots_ff[rd_ptr_ff];

   // pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = push ? (wr_ptr_ff + PtrW'(1)) : wr_ptr_ff;
      rd_ptr_in = pop ? (rd_ptr_ff + PtrW'(1)) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + (PtrW+1)'(1);
      end else if (pop && !push) begin
         count_in = count_ff - (PtrW+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // run storage
   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_run;
      end
   end

endmodule

[hw/rtl/tcce_back.sv]
module tcce_back (
   input  logic                              clock,
   input  logic                              reset,
   input  tcce_pkg::run_type                 pop_run,
   input  logic                              empty,
   output logic                              pop,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [tcce_pkg::CMD_W-1:0]        rsp_command,
   output logic [tcce_pkg::CELL_W-1:0]       rsp_cell_column,
   output logic [tcce_pkg::CELL_W-1:0]       rsp_cell_row,
   output logic [tcce_pkg::GLYPH_W-1:0]      rsp_glyph_code,
   output logic                              rsp_last_of_run
);

   localparam int CellW  = tcce_pkg::CELL_W;
   localparam int GlyphW = tcce_pkg::GLYPH_W;
   localparam int Slots  = 4;
   localparam int SlotW  = 2;

   // command slots of one run, in issue order
   localparam logic [SlotW-1:0] SLOT_ERASE  = 2'd0;
   localparam logic [SlotW-1:0] SLOT_ACTION = 2'd1;
   localparam logic [SlotW-1:0] SLOT_SCROLL = 2'd2;
   localparam logic [SlotW-1:0] SLOT_CURSOR = 2'd3;

   logic [SlotW-1:0]            step_ff;
   logic [SlotW-1:0]            step_in;
   logic                        rsp_valid_ff;
   logic                        rsp_valid_in;
   tcce_pkg::command_type       rsp_command_ff;
   tcce_pkg::command_type       rsp_command_in;
   logic [CellW-1:0]            rsp_cell_column_ff;
   logic [CellW-1:0]            rsp_cell_column_in;
   logic [CellW-1:0]            rsp_cell_row_ff;
   logic [CellW-1:0]            rsp_cell_row_in;
   logic [GlyphW-1:0]           rsp_glyph_code_ff;
   logic [GlyphW-1:0]           rsp_glyph_code_in;
   logic                        rsp_last_of_run_ff;
   logic                        rsp_last_of_run_in;

   logic [Slots-1:0]            enabled;
   logic [Slots-1:0]            avail;
   logic [SlotW-1:0]            pick;
   logic                        later;
   logic                        load;

   assign enabled[SLOT_ERASE]  = pop_run.show;
   assign enabled[SLOT_ACTION] = pop_run.act_valid;
   assign enabled[SLOT_SCROLL] = pop_run.scroll;
   assign enabled[SLOT_CURSOR] = pop_run.show;

   // output register free or being drained this cycle
   assign load = !empty && (!rsp_valid_ff || !rsp_stall);

   // pick the next pending command of the head run
   always_comb begin
      avail = '0;
      pick  = SLOT_CURSOR;
      later = 1'b0;
      for (int i = 0; i < Slots; i++) begin
         avail[i] = enabled[i] && (SlotW'(i) >= step_ff);
      end
      for (int i = Slots - 1; i >= 0; i--) begin
         if (avail[i]) begin
            pick = SlotW'(i);
         end
      end
      for (int i = 0; i < Slots; i++) begin
         if (avail[i] && (SlotW'(i) > pick)) begin
            later = 1'b1;
         end
      end
   end

   // command fields for the picked slot
   always_comb begin
      rsp_command_in     = tcce_pkg::CMD_SCROLL;
      rsp_cell_column_in = '0;
      rsp_cell_row_in    = '0;
      rsp_glyph_code_in  = '0;
      unique case (pick)
         SLOT_ERASE: begin
            rsp_command_in     = tcce_pkg::CMD_ERASE_CURSOR;
            rsp_cell_column_in = pop_run.old_column;
            rsp_cell_row_in    = pop_run.old_row;
         end
         SLOT_ACTION: begin
            rsp_command_in     = pop_run.act_clear ? tcce_pkg::CMD_CLEAR_CELL
                                                   : tcce_pkg::CMD_DRAW_GLYPH;
            rsp_cell_column_in = pop_run.act_column;
            rsp_cell_row_in    = pop_run.old_row;
            rsp_glyph_code_in  = pop_run.glyph;
         end
         SLOT_SCROLL: begin
            rsp_command_in = tcce_pkg::CMD_SCROLL;
         end
         SLOT_CURSOR: begin
            rsp_command_in     = tcce_pkg::CMD_DRAW_CURSOR;
            rsp_cell_column_in = pop_run.new_column;
            rsp_cell_row_in    = pop_run.new_row;
         end
         default: begin
         end
      endcase
      rsp_last_of_run_in = !later;
   end

   // sequencer step and valid
   always_comb begin
      pop          = load && !later;
      step_in      = step_ff;
      rsp_valid_in = rsp_valid_ff;
      if (load) begin
         step_in      = later ? (pick + SlotW'(1)) : '0;
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // result word register
   always_ff @(posedge clock) begin
      if (load) begin
         rsp_command_ff     <= rsp_command_in;
         rsp_cell_column_ff <= rsp_cell_column_in;
         rsp_cell_row_ff    <= rsp_cell_row_in;
         rsp_glyph_code_ff  <= rsp_glyph_code_in;
         rsp_last_of_run_ff <= rsp_last_of_run_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_command     = rsp_command_ff;
   assign rsp_cell_column = rsp_cell_column_ff;
   assign rsp_cell_row    = rsp_cell_row_ff;
   assign rsp_glyph_code  = rsp_glyph_code_ff;
   assign rsp_last_of_run = rsp_last_of_run_ff;

endmodule

[hw/rtl/text_console_cursor_engine_unit.sv]
// Cursor engine for a character-cell text console. Each character word on the
// req_ side moves the cursor and yields a run of one to four drawing commands on
// the rsp_ side (erase cursor, draw glyph or clear cell, scroll, draw cursor),
// with last_of_run set on the final one; with the cursor hidden a character that
// draws nothing yields no word at all. The front end takes one character per
// cycle while its four-run queue has room; the back end issues one command per
// cycle from the queue head while rsp_stall is low.
// The csr_ registers (column count, row count, cursor visibility) are meant to be
// written while no run is outstanding.
module text_console_cursor_engine_unit (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [tcce_pkg::CHAR_W-1:0]       req_char_byte,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [tcce_pkg::CMD_W-1:0]        rsp_command,
   output logic [tcce_pkg::CELL_W-1:0]       rsp_cell_column,
   output logic [tcce_pkg::CELL_W-1:0]       rsp_cell_row,
   output logic [tcce_pkg::GLYPH_W-1:0]      rsp_glyph_code,
   output logic                              rsp_last_of_run,
   input  logic                              csr_write_enable,
   input  logic [tcce_pkg::CSR_W-1:0]        csr_index,
   input  logic [tcce_pkg::COUNT_W-1:0]      csr_write_data
);

   tcce_pkg::cfg_type cfg_ff;
   tcce_pkg::cfg_type cfg_in;
   tcce_pkg::run_type push_run;
   tcce_pkg::run_type pop_run;
   logic              push;
   logic              pop;
   logic              queue_full;
   logic              queue_empty;

   // configuration registers
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            tcce_pkg::CSR_COLUMN_COUNT: cfg_in.column_count = csr_write_data;
            tcce_pkg::CSR_ROW_COUNT:    cfg_in.row_count    = csr_write_data;
            tcce_pkg::CSR_SHOW_CURSOR:  cfg_in.show_cursor  = csr_write_data[0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.column_count <= tcce_pkg::COLUMN_COUNT_RESET;
         cfg_ff.row_count    <= tcce_pkg::ROW_COUNT_RESET;
         cfg_ff.show_cursor  <= tcce_pkg::SHOW_CURSOR_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   tcce_front u_front (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg_ff),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_char_byte (req_char_byte),
      .push          (push),
      .push_run      (push_run),
      .queue_full    (queue_full)
   );

   tcce_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_run (push_run),
      .full     (queue_full),
      .pop      (pop),
      .pop_run  (pop_run),
      .empty    (queue_empty)
   );

   tcce_back u_back (
      .clock           (clock),
      .reset           (reset),
      .pop_run         (pop_run),
      .empty           (queue_empty),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_command     (rsp_command),
      .rsp_cell_column (rsp_cell_column),
      .rsp_cell_row    (rsp_cell_row),
      .rsp_glyph_code  (rsp_glyph_code),
      .rsp_last_of_run (rsp_last_of_run)
   );

endmodule

[hw/rtl/tcce_checker.sv]
module tcce_props (
   input logic                              clock,
   input logic                              reset,
   input logic                              rsp_valid,
   input logic                              rsp_stall,
   input logic [tcce_pkg::CMD_W-1:0]        rsp_command,
   input logic [tcce_pkg::CELL_W-1:0]       rsp_cell_column,
   input logic [tcce_pkg::CELL_W-1:0]       rsp_cell_row,
   input logic [tcce_pkg::GLYPH_W-1:0]      rsp_glyph_code,
   input logic                              rsp_last_of_run
);

   // a stalled result word stays offered
   a_valid_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result word dropped while stalled");

   // a stalled result word keeps its payload
   a_payload_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_command) && $stable(rsp_cell_column)
         && $stable(rsp_cell_row) && $stable(rsp_glyph_code) && $stable(rsp_last_of_run))
      else $error("result payload changed while stalled");

   // scroll carries no cell and no glyph
   a_scroll_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_command == tcce_pkg::CMD_SCROLL) |->
         (rsp_cell_column == '0) && (rsp_cell_row == '0) && (rsp_glyph_code == '0))
      else $error("scroll word with nonzero fields");

   // drawn glyphs are printable
   a_glyph_printable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_command == tcce_pkg::CMD_DRAW_GLYPH) |->
         ({1'b0, rsp_glyph_code} >= tcce_pkg::CHAR_PRINT_LO)
         && ({1'b0, rsp_glyph_code} <= tcce_pkg::CHAR_PRINT_HI))
      else $error("draw glyph outside printable range");

   // an erase never closes a run, and a cursor redraw always does
   a_cursor_pairing: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && ((rsp_command == tcce_pkg::CMD_ERASE_CURSOR && rsp_last_of_run)
         || (rsp_command == tcce_pkg::CMD_DRAW_CURSOR && !rsp_last_of_run)) |-> 1'b0)
      else $error("cursor erase or redraw in wrong place of run");

endmodule

bind text_console_cursor_engine_unit tcce_props u_tcce_props (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_command     (rsp_command),
   .rsp_cell_column (rsp_cell_column),
   .rsp_cell_row    (rsp_cell_row),
   .rsp_glyph_code  (rsp_glyph_code),
   .rsp_last_of_run (rsp_last_of_run)
);

[sim/tcce_checker.sv]
// watches both channels and the register port of the cursor engine, predicts
// the drawing commands of every accepted character and compares them in order
module tcce_checker
   import tcce_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_stall,
   input  logic [CHAR_W-1:0]   req_char_byte,
   input  logic                rsp_valid,
   input  logic                rsp_stall,
   input  logic [CMD_W-1:0]    rsp_command,
   input  logic [CELL_W-1:0]   rsp_cell_column,
   input  logic [CELL_W-1:0]   rsp_cell_row,
   input  logic [GLYPH_W-1:0]  rsp_glyph_code,
   input  logic                rsp_last_of_run,
   input  logic                csr_write_enable,
   input  logic [CSR_W-1:0]    csr_index,
   input  logic [COUNT_W-1:0]  csr_write_data,
   output int unsigned         fail_count,
   output int unsigned         pending
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int REPORT_LIMIT = 10;

   typedef struct {
      command_type        command;
      logic [CELL_W-1:0]  column;
      logic [CELL_W-1:0]  row;
      logic [GLYPH_W-1:0] glyph;
      logic               last;
   } draw_cmd_type;

   // commands still owed by the block, oldest first
   draw_cmd_type draw_queue [$];
   draw_cmd_type want;

   // shadow registers and cursor
   logic [COUNT_W-1:0] column_count_q;
   logic [COUNT_W-1:0] row_count_q;
   logic               show_q;
   logic [CELL_W-1:0]  cur_col;
   logic [CELL_W-1:0]  cur_row;

   // zero means one cell, anything past the axis limit is clamped
   function automatic int screen_extent(input logic [COUNT_W-1:0] value);
      if (value == '0) return 1;
      if (int'(value) > MAX_CELLS_PER_AXIS) return MAX_CELLS_PER_AXIS;
      return int'(value);
   endfunction

   function automatic void push_cmd(input command_type cmd, input int col, input int row,
                                    input logic [GLYPH_W-1:0] glyph);
      draw_cmd_type item;
      item.command = cmd;
      item.column  = CELL_W'(col);
      item.row     = CELL_W'(row);
      item.glyph   = glyph;
      item.last    = 1'b0;
      draw_queue.push_back(item);
   endfunction

   // move the cursor for one character and queue the run of commands it causes
   function automatic void plan_char(input logic [CHAR_W-1:0] ch);
      int cols;
      int rows;
      int col;
      int row;
      int next_stop;
      int first;
      cols  = screen_extent(column_count_q);
      rows  = screen_extent(row_count_q);
      col   = int'(cur_col);
      row   = int'(cur_row);
      first = draw_queue.size();
      if (show_q) push_cmd(CMD_ERASE_CURSOR, col, row, '0);
      if (ch == CHAR_LF) begin
         col = 0;
         row++;
      end else if (ch == CHAR_CR) begin
         col = 0;
      end else if (ch == CHAR_TAB) begin
         next_stop = (col / TAB_STOP + 1) * TAB_STOP;
         if (next_stop >= cols) begin
            col = 0;
            row++;
         end else begin
            col = next_stop;
         end
      end else if (ch == CHAR_BS) begin
         // nothing to step back over in the first column
         if (col > 0) begin
            col--;
            push_cmd(CMD_CLEAR_CELL, col, row, '0);
         end
      end else if (ch >= CHAR_PRINT_LO && ch <= CHAR_PRINT_HI) begin
         push_cmd(CMD_DRAW_GLYPH, col, row, ch[GLYPH_W-1:0]);
         col++;
      end
      // wrap, then scroll when past the bottom row
      if (col >= cols) begin
         col = 0;
         row++;
      end
      if (row >= rows) begin
         push_cmd(CMD_SCROLL, 0, 0, '0);
         row = rows - 1;
      end
      cur_col = CELL_W'(col);
      cur_row = CELL_W'(row);
      if (show_q) push_cmd(CMD_DRAW_CURSOR, int'(cur_col), int'(cur_row), '0);
      if (draw_queue.size() > first) draw_queue[draw_queue.size()-1].last = 1'b1;
   endfunction

   function automatic void note_failure(input string msg);
      fail_count++;
      if (fail_count <= REPORT_LIMIT) $display("%0t: %s", $realtime, msg);
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         column_count_q = COLUMN_COUNT_RESET;
         row_count_q    = ROW_COUNT_RESET;
         show_q         = SHOW_CURSOR_RESET;
         cur_col        = '0;
         cur_row        = '0;
         draw_queue.delete();
      end else begin
         // register writes
         if (csr_write_enable) begin
            case (csr_index)
               CSR_COLUMN_COUNT: column_count_q = csr_write_data;
               CSR_ROW_COUNT:    row_count_q    = csr_write_data;
               CSR_SHOW_CURSOR:  show_q         = csr_write_data[0];
               default: ;
            endcase
         end
         // accepted character word
         if (req_valid && !req_stall) plan_char(req_char_byte);
         // accepted command word
         if (rsp_valid && !rsp_stall) begin
            if (draw_queue.size() == 0) begin
               note_failure($sformatf("unexpected word: cmd %0d col %0d row %0d glyph %0d last %0d",
                  rsp_command, rsp_cell_column, rsp_cell_row, rsp_glyph_code,
                  rsp_last_of_run));
            end else begin
               want = draw_queue.pop_front();
               if (rsp_command !== want.command || rsp_cell_column !== want.column ||
                   rsp_cell_row !== want.row || rsp_glyph_code !== want.glyph ||
                   rsp_last_of_run !== want.last) begin
                  note_failure($sformatf(
                     "mismatch: expected cmd %0d col %0d row %0d glyph %0d last %0d, got %0d %0d %0d %0d %0d",
                     want.command, want.column, want.row, want.glyph, want.last,
                     rsp_command, rsp_cell_column, rsp_cell_row, rsp_glyph_code,
                     rsp_last_of_run));
               end
            end
         end
      end
      pending = draw_queue.size();
   end

endmodule

[sim/tb_top.sv]
// stimulus and verdict for the cursor engine; checking lives in tcce_checker
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import tcce_pkg::*;

   localparam int SETTLE_CYCLES = 24;
   localparam int HOLD_CYCLES   = 200;
   localparam int PHASE_ITEMS   = 13;
   localparam int NUM_PHASES    = 8;
   localparam int HOLD_PHASE    = 2;
   localparam logic [CSR_W-1:0] CSR_SPARE = 2'd3;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic [CHAR_W-1:0]   req_char_byte = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [CMD_W-1:0]    rsp_command;
   logic [CELL_W-1:0]   rsp_cell_column;
   logic [CELL_W-1:0]   rsp_cell_row;
   logic [GLYPH_W-1:0]  rsp_glyph_code;
   logic                rsp_last_of_run;
   logic                csr_write_enable = 1'b0;
   logic [CSR_W-1:0]    csr_index = '0;
   logic [COUNT_W-1:0]  csr_write_data = '0;
   int unsigned         fail_count;
   int unsigned         pending;

   // set by the stimulus process; rx_quiet and long_hold_req are read by the receiver
   logic tx_quiet      = 1'b0;
   logic rx_quiet      = 1'b0;
   logic long_hold_req = 1'b0;

   // screen settings walked by the random part; the last phase draws its own
   int phase_cols [0:NUM_PHASES-1] = '{8, 1, 12, 256, 0, 300, 5, 511};
   int phase_rows [0:NUM_PHASES-1] = '{4, 1, 3, 256, 0, 511, 2, 7};
   int phase_show [0:NUM_PHASES-1] = '{1, 1, 1, 0, 1, 1, 0, 1};

   logic [CHAR_W-1:0] lead_chars [0:15] = '{
      8'h41, CHAR_PRINT_LO, CHAR_PRINT_HI, 8'h7F, 8'hFF, CHAR_BS, CHAR_BS, CHAR_BS,
      CHAR_BS, CHAR_CR, CHAR_TAB, CHAR_TAB, CHAR_LF, 8'h7A, 8'h1F, 8'h00};

   always #5 clock = ~clock;

   text_console_cursor_engine_unit u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_char_byte    (req_char_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_command      (rsp_command),
      .rsp_cell_column  (rsp_cell_column),
      .rsp_cell_row     (rsp_cell_row),
      .rsp_glyph_code   (rsp_glyph_code),
      .rsp_last_of_run  (rsp_last_of_run),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   tcce_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_char_byte    (req_char_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_command      (rsp_command),
      .rsp_cell_column  (rsp_cell_column),
      .rsp_cell_row     (rsp_cell_row),
      .rsp_glyph_code   (rsp_glyph_code),
      .rsp_last_of_run  (rsp_last_of_run),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .fail_count       (fail_count),
      .pending          (pending)
   );

   // mostly short pauses, now and then a long one
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // mostly real console traffic, some arbitrary bytes
   function automatic logic [CHAR_W-1:0] pick_char();
      int r;
      r = $urandom_range(0, 99);
      if (r < 40) return CHAR_W'($urandom_range(CHAR_PRINT_LO, CHAR_PRINT_HI));
      if (r < 50) return CHAR_LF;
      if (r < 58) return CHAR_CR;
      if (r < 68) return CHAR_TAB;
      if (r < 80) return CHAR_BS;
      return CHAR_W'($urandom_range(0, 255));
   endfunction

   // offer one character word, hold it until taken, then idle for the given gap
   task automatic send_char(input logic [CHAR_W-1:0] ch, input int gap);
      logic taken;
      req_valid     <= 1'b1;
      req_char_byte <= ch;
      taken = 1'b0;
      while (!taken) begin
         @(negedge clock);
         taken = !req_stall;
         @(posedge clock);
      end
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // let every owed command come out, then let a silent run finish too
   task automatic drain_and_settle();
      req_valid <= 1'b0;
      do @(negedge clock); while (pending != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_W-1:0] idx, input logic [COUNT_W-1:0] value);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= value;
      @(posedge clock);
   endtask

   task automatic set_screen(input int cols, input int rows, input int show);
      drain_and_settle();
      write_reg(CSR_COLUMN_COUNT, COUNT_W'(cols));
      write_reg(CSR_ROW_COUNT, COUNT_W'(rows));
      write_reg(CSR_SHOW_CURSOR, COUNT_W'(show));
      csr_write_enable <= 1'b0;
   endtask

   // receiver: random stalls, quiet stretches, one long hold-off on request
   initial begin
      int stall_left;
      int hold_count;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (long_hold_req) begin
            rsp_stall <= 1'b1;
            for (hold_count = 0; hold_count < HOLD_CYCLES; hold_count++) @(posedge clock);
            long_hold_req = 1'b0;
            stall_left = 0;
         end else if (rx_quiet) begin
            rsp_stall <= 1'b0;
         end else if (stall_left > 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else begin
            rsp_stall <= 1'b0;
            if ($urandom_range(0, 99) < 25) stall_left = pick_gap() + 1;
         end
      end
   end

   // run limit
   initial begin
      #5_000_000;
      $display("TEST FAILED");
      $finish;
   end

   // stimulus and verdict
   initial begin
      int gap;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: field extremes and every handled control byte at the reset screen
      foreach (lead_chars[i]) send_char(lead_chars[i], pick_gap());
      // tab out to column 72, then shrink the screen under the cursor
      repeat (9) send_char(CHAR_TAB, pick_gap());
      set_screen(16, 1, 1);
      send_char(8'h51, 0);
      // hidden cursor: a silent byte, a glyph and a scrolling line feed
      set_screen(16, 1, 0);
      send_char(8'h1F, pick_gap());
      send_char(8'h78, pick_gap());
      send_char(CHAR_LF, pick_gap());
      // the unused register index must change nothing
      drain_and_settle();
      write_reg(CSR_SPARE, '1);
      csr_write_enable <= 1'b0;

      // random part, one screen setting per phase
      for (int p = 0; p < NUM_PHASES; p++) begin
         if (p == NUM_PHASES - 1) begin
            set_screen($urandom_range(1, 40), $urandom_range(1, 10), $urandom_range(0, 1));
         end else begin
            set_screen(phase_cols[p], phase_rows[p], phase_show[p]);
         end
         tx_quiet = ($urandom_range(0, 3) == 0);
         rx_quiet = ($urandom_range(0, 3) == 0);
         if (p == HOLD_PHASE) begin
            // receiver holds off while the sender keeps pushing
            tx_quiet = 1'b1;
            rx_quiet = 1'b0;
            long_hold_req = 1'b1;
         end
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            gap = tx_quiet ? 0 : pick_gap();
            send_char(pick_char(), gap);
         end
      end
      rx_quiet = 1'b0;

      drain_and_settle();
      if (fail_count == 0 && pending == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
